@@ design/kbu_pkg.sv @@
`default_nettype none

package kbu_pkg;

  // Kind of transaction on the input channel
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_RX    = 2'd3
  } kbu_mode_e;

  // I/O port numbers
  localparam logic [7:0] PORT_SCAN      = 8'd0;
  localparam logic [7:0] PORT_UART_DATA = 8'd1;
  localparam logic [7:0] PORT_UART_STAT = 8'd2;

  // Bit positions in a port 0 write
  localparam int unsigned SCAN_CLK_BIT = 0;
  localparam int unsigned SCAN_RST_BIT = 1;
  localparam int unsigned DECK_LED_BIT = 4;

  // Status and read constants
  localparam logic [7:0] ST_READY     = 8'h80;
  localparam logic [7:0] ST_TX_EMPTY  = 8'h40;
  localparam logic [7:0] ROW_PAST_END = 8'hFF;

  // Key matrix geometry
  localparam int unsigned KEY_COLS = 7;

  // One result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       deck_led;
  } kbu_result_t;

endpackage

`default_nettype wire

@@ design/keyboard_scan_and_uart_ports_top.sv @@
// Keyboard scan and serial port block.
// Input channel (in_valid_i / in_stall_o): one transaction is a key event,
// a port write, a port read or a received serial byte, chosen by mode_i.
// Output channel (out_valid_o / out_stall_i): exactly one result per input
// transaction, carrying read data, an optional transmit byte and the tape
// LED state after that transaction.
// The result appears in the output register in the cycle after the input
// transaction is accepted. One transaction per cycle when not stalled; the
// whole step is one pass through the core logic into the output register.
// When the receiver stalls while a result is held, in_stall_o rises and the
// held result stays unchanged until it is taken; a new input is accepted in
// the same cycle that the held result leaves.
// Reset clears the key matrix, the scan snapshot, the scan counter, the
// last port 0 value, the tape LED and the receive holding register, and
// empties the output register.
`default_nettype none

module keyboard_scan_and_uart_ports_top #(
  parameter int unsigned KEY_ROWS = 9
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] port_i,
  input  wire logic [7:0] data_i,
  input  wire logic [3:0] key_row_i,
  input  wire logic [2:0] key_col_i,
  input  wire logic       key_down_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      read_data_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o,
  output logic            deck_led_out_o
);

  logic                 accept;
  logic                 out_valid_q;
  kbu_pkg::kbu_result_t result;
  kbu_pkg::kbu_result_t result_q;

  // Input is taken whenever the output register is free or being emptied
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  kbu_core #(
    .KEY_ROWS(KEY_ROWS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .mode_i    (mode_i),
    .port_i    (port_i),
    .data_i    (data_i),
    .key_row_i (key_row_i),
    .key_col_i (key_col_i),
    .key_down_i(key_down_i),
    .result_o  (result)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = result_q.read_data;
  assign tx_valid_o     = result_q.tx_valid;
  assign tx_byte_o      = result_q.tx_byte;
  assign deck_led_out_o = result_q.deck_led;

  // A transmit result never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tx_valid_o) |-> (read_data_o == 8'h00))
    else $error("transmit result with nonzero read data");

  // Transmit byte is zero unless a byte is emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> (tx_byte_o == 8'h00))
    else $error("transmit byte set without transmit valid");

  // Input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // Every accepted transaction yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire

@@ design/kbu_core.sv @@
`default_nettype none

module kbu_core #(
  parameter int unsigned KEY_ROWS = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic [7:0]            port_i,
  input  wire logic [7:0]            data_i,
  input  wire logic [3:0]            key_row_i,
  input  wire logic [2:0]            key_col_i,
  input  wire logic                  key_down_i,
  output kbu_pkg::kbu_result_t       result_o
);

  localparam int unsigned CntW = $clog2(KEY_ROWS + 1);
  localparam int unsigned ColW = kbu_pkg::KEY_COLS;

  logic [ColW-1:0] live_q [KEY_ROWS];
  logic [ColW-1:0] live_d [KEY_ROWS];
  logic [ColW-1:0] snap_q [KEY_ROWS];
  logic [ColW-1:0] snap_d [KEY_ROWS];
  logic [CntW-1:0] scan_row_q, scan_row_d;
  logic [7:0]      last_port0_q, last_port0_d;
  logic            deck_led_q, deck_led_d;
  logic [7:0]      rx_byte_q, rx_byte_d;
  logic            rx_full_q, rx_full_d;

  logic            key_hit;
  logic [ColW-1:0] key_mask;
  logic [7:0]      falls;
  logic [ColW-1:0] snap_row;
  logic            row_past_end;
  logic            rx_ready;

  // Key event decode: out-of-range rows and column 7 are dropped
  assign key_hit  = ({1'b0, key_row_i} < 5'(KEY_ROWS)) && (key_col_i != 3'd7);
  assign key_mask = ColW'(1) << key_col_i;
  assign falls    = last_port0_q & ~data_i;
  assign rx_ready = rx_full_q && deck_led_q;

  // Snapshot row currently addressed by the scan counter
  assign row_past_end = (scan_row_q >= CntW'(KEY_ROWS));
  always_comb begin
    snap_row = '0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      if (scan_row_q == CntW'(r)) begin
        snap_row = snap_q[r];
      end
    end
  end

  // Next state and result
  always_comb begin
    live_d       = live_q;
    snap_d       = snap_q;
    scan_row_d   = scan_row_q;
    last_port0_d = last_port0_q;
    deck_led_d   = deck_led_q;
    rx_byte_d    = rx_byte_q;
    rx_full_d    = rx_full_q;
    result_o     = '0;

    unique case (kbu_pkg::kbu_mode_e'(mode_i))
      kbu_pkg::MODE_KEY: begin
        for (int r = 0; r < KEY_ROWS; r++) begin
          if (key_hit && (key_row_i == 4'(r))) begin
            live_d[r] = key_down_i ? (live_q[r] | key_mask) : (live_q[r] & ~key_mask);
          end
        end
      end
      kbu_pkg::MODE_WRITE: begin
        unique case (port_i)
          kbu_pkg::PORT_SCAN: begin
            last_port0_d = data_i;
            if (falls[kbu_pkg::SCAN_CLK_BIT] && !row_past_end) begin
              scan_row_d = scan_row_q + CntW'(1);
            end
            // reset edge wins over a simultaneous clock edge
            if (falls[kbu_pkg::SCAN_RST_BIT]) begin
              scan_row_d = '0;
              snap_d     = live_q;
            end
            deck_led_d = data_i[kbu_pkg::DECK_LED_BIT];
          end
          kbu_pkg::PORT_UART_DATA: begin
            result_o.tx_valid = 1'b1;
            result_o.tx_byte  = data_i;
          end
          default: ;
        endcase
      end
      kbu_pkg::MODE_READ: begin
        unique case (port_i)
          kbu_pkg::PORT_SCAN: begin
            result_o.read_data = row_past_end ? kbu_pkg::ROW_PAST_END : {1'b1, ~snap_row};
          end
          kbu_pkg::PORT_UART_DATA: begin
            if (rx_ready) begin
              rx_full_d          = 1'b0;
              result_o.read_data = rx_byte_q;
            end
          end
          kbu_pkg::PORT_UART_STAT: begin
            result_o.read_data = kbu_pkg::ST_TX_EMPTY | (rx_ready ? kbu_pkg::ST_READY : 8'h00);
          end
          default: ;
        endcase
      end
      kbu_pkg::MODE_RX: begin
        rx_byte_d = data_i;
        rx_full_d = 1'b1;
      end
    endcase

    result_o.deck_led = deck_led_d;
  end

  // State registers, updated once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        live_q[r] <= '0;
        snap_q[r] <= '0;
      end
      scan_row_q   <= '0;
      last_port0_q <= '0;
      deck_led_q   <= 1'b0;
      rx_byte_q    <= '0;
      rx_full_q    <= 1'b0;
    end else if (en_i) begin
      live_q       <= live_d;
      snap_q       <= snap_d;
      scan_row_q   <= scan_row_d;
      last_port0_q <= last_port0_d;
      deck_led_q   <= deck_led_d;
      rx_byte_q    <= rx_byte_d;
      rx_full_q    <= rx_full_d;
    end
  end

  // Scan counter saturates at the row count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_row_q <= CntW'(KEY_ROWS))
    else $error("scan row counter past saturation");

  // Holding register only drains through an enabled port 1 read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(rx_full_q) |-> $past(en_i && (mode_i == kbu_pkg::MODE_READ) &&
                               (port_i == kbu_pkg::PORT_UART_DATA) && deck_led_q))
    else $error("receive holding register cleared without a data read");

  // LED only moves on a port 0 write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(deck_led_q) |-> $past(en_i && (mode_i == kbu_pkg::MODE_WRITE) &&
                                   (port_i == kbu_pkg::PORT_SCAN)))
    else $error("LED changed without a port 0 write");

endmodule

`default_nettype wire
